### hw/rtl/htbd_pkg.sv
// Shared types and constants of the Huffman tree bit decoder.
// Holds the tree phase enum and the result payload type.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package htbd_pkg;

    // bits of a leaf symbol and width of the symbol bit counter
    localparam int SYM_BITS = 8;
    localparam int SYM_CNT_W = 3;

    // byte count and length register width
    localparam int LEN_W = 48;

    // entries of the output queue
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = 2;

    // tree loading and decoding phases
    typedef enum logic [4:0] {
        PH_FLAG   = 5'b00001,
        PH_SYMBOL = 5'b00010,
        PH_DECODE = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_ERROR  = 5'b10000
    } phase_t;

    // one result item
    typedef struct packed {
        logic [SYM_BITS-1:0] out_byte;
        logic                last_byte;
        logic                tree_error;
    } result_t;

    // result handed from the decode pipe to the output queue
    typedef struct packed {
        logic    valid;
        result_t result;
    } push_t;

endpackage

`default_nettype wire

### hw/rtl/htbd_channels.sv
// Valid/ready channel interfaces of the Huffman tree bit decoder.
// htbd_code_if carries coded bits in, htbd_sym_if carries decoded bytes out.
// Depends on nothing; compiled after htbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface htbd_code_if;
    logic valid;
    logic ready;
    logic in_bit;
    logic start_req;

    modport source (output valid, output in_bit, output start_req, input ready);
    modport sink (input valid, input in_bit, input start_req, output ready);
endinterface

interface htbd_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;
    logic       tree_error;

    modport source (output valid, output out_byte, output last_byte, output tree_error,
                    input ready);
    modport sink (input valid, input out_byte, input last_byte, input tree_error,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/htbd_out_queue.sv
// Three-entry result queue that decouples the decode pipe from the receiver.
// Uses htbd_pkg::push_t and htbd_pkg::result_t, drives an htbd_sym_if source.
// Reports its fill level so the top level can throttle input transfers.
`timescale 1ns / 1ps
`default_nettype none

module htbd_out_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire htbd_pkg::push_t               push,
    output logic [htbd_pkg::OQ_PTR_W-1:0]      fill,
    htbd_sym_if.source                         sym_ch
);

    htbd_pkg::result_t                 entry_reg [0:htbd_pkg::OQ_DEPTH-1];
    logic [htbd_pkg::OQ_PTR_W-1:0]     wr_ptr_reg;
    logic [htbd_pkg::OQ_PTR_W-1:0]     wr_ptr_next;
    logic [htbd_pkg::OQ_PTR_W-1:0]     rd_ptr_reg;
    logic [htbd_pkg::OQ_PTR_W-1:0]     rd_ptr_next;
    logic [htbd_pkg::OQ_PTR_W-1:0]     count_reg;
    logic [htbd_pkg::OQ_PTR_W-1:0]     count_next;
    logic                              pop;
    htbd_pkg::result_t                 head;

    localparam logic [htbd_pkg::OQ_PTR_W-1:0] LAST_SLOT =
        htbd_pkg::OQ_PTR_W'(htbd_pkg::OQ_DEPTH - 1);

    // head of queue toward the receiver
    assign head              = entry_reg[rd_ptr_reg];
    assign sym_ch.valid      = (count_reg != '0);
    assign sym_ch.out_byte   = head.out_byte;
    assign sym_ch.last_byte  = head.last_byte;
    assign sym_ch.tree_error = head.tree_error;
    assign pop               = sym_ch.valid && sym_ch.ready;
    assign fill              = count_reg;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.result;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/huffman_tree_bit_decoder.sv
// Top level of the Huffman tree bit decoder: tree rebuild and bit-wise decode.
// Depends on htbd_pkg, htbd_channels (interfaces) and htbd_out_queue.
//
// Usage:
//   code_ch (sink) takes one coded bit per transfer. start_req marks the first
//   bit of a stream; that bit is the first node flag of a preorder tree
//   (0 = internal node, 1 = leaf followed by 8 symbol bits, MSB first).
//   Once the tree is complete each bit steps left (0) or right (1); reaching
//   a leaf produces one transfer on sym_ch (source). After total_length bytes
//   the final one carries last_byte and further bits are dropped until the
//   next start_req. An overflow of the node or stack store gives one transfer
//   with tree_error set and the stream is dropped until start_req.
//   cfg_we / cfg_wdata write total_length; write it only while idle.
// Timing:
//   One bit per cycle while code_ch.ready is high. Each tree step reads the node memory into a
//   read register, and that registered entry picks the child of the step that comes after it.
//   A byte reaches sym_ch through the node read register and the result queue.
// Reset and stall:
//   rst_n clears all control state at once; node and stack memories are not
//   cleared, tree loading starts fresh. A 3-entry result queue holds results
//   while the receiver stalls; code_ch.ready drops once the queue plus the
//   bit in flight would fill it.
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_bit_decoder #(
    parameter int NODE_DEPTH  = 512,
    parameter int STACK_DEPTH = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    htbd_code_if.sink                          code_ch,
    htbd_sym_if.source                         sym_ch,
    input  wire logic                          cfg_we,
    input  wire logic [htbd_pkg::LEN_W-1:0]    cfg_wdata
);

    // widths that follow from the store depths
    localparam int NAW = $clog2(NODE_DEPTH);
    localparam int NCW = $clog2(NODE_DEPTH + 1);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SLW = $clog2(STACK_DEPTH + 1);
    localparam int ENW = 1 + htbd_pkg::SYM_BITS + NAW;
    localparam int LEAF_POS = ENW - 1;
    localparam int SYM_LSB = NAW;

    localparam logic [NCW-1:0] NODE_FULL  = NCW'(NODE_DEPTH);
    localparam logic [SLW-1:0] STACK_FULL = SLW'(STACK_DEPTH);
    localparam logic [htbd_pkg::SYM_CNT_W-1:0] SYM_LAST =
        htbd_pkg::SYM_CNT_W'(htbd_pkg::SYM_BITS - 1);

    // memories: node entry is {leaf, symbol, right link}
    logic [ENW-1:0]  node_mem [0:NODE_DEPTH-1];
    logic [NAW-1:0]  stack_mem [0:STACK_DEPTH-1];
    logic [ENW-1:0]  node_rd_reg;
    logic [NAW-1:0]  stack_rd_reg;

    // control state
    htbd_pkg::phase_t               phase_reg, phase_next;
    logic [NCW-1:0]                 nfn_reg, nfn_next;
    logic [SLW-1:0]                 level_reg, level_next;
    logic [htbd_pkg::SYM_CNT_W-1:0] sym_cnt_reg, sym_cnt_next;
    logic [htbd_pkg::SYM_BITS-1:0]  shift_reg, shift_next;
    logic [htbd_pkg::LEN_W-1:0]     bytes_reg, bytes_next;
    logic [htbd_pkg::LEN_W-1:0]     total_reg;
    logic [NAW-1:0]                 cur_idx_reg, cur_idx_next;
    logic [ENW-1:0]                 cur_entry_reg, cur_entry_next;
    logic [ENW-1:0]                 root_reg, root_next;
    logic                           s1_valid_reg, s1_valid_next;
    logic                           s1_err_reg, s1_err_next;
    logic [NAW-1:0]                 s1_addr_reg, s1_addr_next;
    logic                           link_pend_reg, link_pend_next;
    logic [NAW-1:0]                 link_addr_reg, link_addr_next;
    logic [NAW-1:0]                 link_data_reg, link_data_next;

    // datapath signals
    logic                           accept;
    logic                           start_now;
    logic [NCW-1:0]                 nfn_base;
    logic [SLW-1:0]                 level_base;
    logic                           s1_dec;
    logic                           s1_leaf;
    logic [htbd_pkg::LEN_W-1:0]     bytes_inc;
    logic                           last_if_emit;
    logic                           len_reached;
    logic [htbd_pkg::LEN_W-1:0]     bytes_eff;
    htbd_pkg::phase_t               phase_eff;
    logic [NAW-1:0]                 cur_idx_eff;
    logic [ENW-1:0]                 cur_entry_eff;
    logic [NAW-1:0]                 child_addr;
    logic [NAW-1:0]                 node_raddr;
    logic                           leaf_we;
    logic [ENW-1:0]                 leaf_entry;
    logic                           node_we;
    logic [NAW-1:0]                 node_waddr;
    logic [ENW-1:0]                 node_wdata;
    logic                           stack_we;
    logic [SAW-1:0]                 stack_waddr;
    logic [SAW-1:0]                 stack_raddr;
    logic [NCW-1:0]                 nfn_inc;
    logic [htbd_pkg::SYM_BITS-1:0]  shift_in;
    logic [htbd_pkg::OQ_PTR_W-1:0]  q_fill;
    logic [htbd_pkg::OQ_PTR_W:0]    q_claim;
    htbd_pkg::push_t                push;

    // input transfer, throttled by queue room
    assign q_claim       = {1'b0, q_fill} + {{htbd_pkg::OQ_PTR_W{1'b0}}, s1_valid_reg};
    assign code_ch.ready = (q_claim < (htbd_pkg::OQ_PTR_W + 1)'(htbd_pkg::OQ_DEPTH));
    assign accept        = code_ch.valid && code_ch.ready;

    // counters as seen by the bit being taken, after a possible restart
    assign start_now  = accept && code_ch.start_req;
    assign nfn_base   = start_now ? '0 : nfn_reg;
    assign level_base = start_now ? '0 : level_reg;

    // resolve the step in flight from last cycle's node read
    assign s1_dec       = s1_valid_reg && !s1_err_reg;
    assign s1_leaf      = s1_dec && node_rd_reg[LEAF_POS];
    assign bytes_inc    = bytes_reg + 1'b1;
    assign last_if_emit = (bytes_inc >= total_reg);
    assign bytes_eff    = s1_leaf ? bytes_inc : bytes_reg;
    assign len_reached  = s1_leaf ? last_if_emit : (bytes_reg >= total_reg);
    assign phase_eff    = (s1_leaf && last_if_emit) ? htbd_pkg::PH_DONE : phase_reg;

    // current node after the step in flight
    always_comb
    begin
        if (s1_dec && node_rd_reg[LEAF_POS])
        begin
            cur_idx_eff   = '0;
            cur_entry_eff = root_reg;
        end
        else if (s1_dec)
        begin
            cur_idx_eff   = s1_addr_reg;
            cur_entry_eff = node_rd_reg;
        end
        else
        begin
            cur_idx_eff   = cur_idx_reg;
            cur_entry_eff = cur_entry_reg;
        end
    end

    // next node: a leaf root stays at the root, else left is the next index
    always_comb
    begin
        if (cur_entry_eff[LEAF_POS])
        begin
            child_addr = '0;
        end
        else if (code_ch.in_bit)
        begin
            child_addr = cur_entry_eff[NAW-1:0];
        end
        else
        begin
            child_addr = cur_idx_eff + 1'b1;
        end
    end

    // result toward the output queue
    always_comb
    begin
        push.valid = s1_valid_reg && (s1_err_reg || node_rd_reg[LEAF_POS]);
        if (s1_err_reg)
        begin
            push.result.out_byte   = '0;
            push.result.last_byte  = 1'b0;
            push.result.tree_error = 1'b1;
        end
        else
        begin
            push.result.out_byte   = node_rd_reg[SYM_LSB +: htbd_pkg::SYM_BITS];
            push.result.last_byte  = last_if_emit;
            push.result.tree_error = 1'b0;
        end
    end

    assign nfn_inc     = nfn_base + 1'b1;
    assign shift_in    = {shift_reg[htbd_pkg::SYM_BITS-2:0], code_ch.in_bit};
    assign leaf_entry  = {1'b1, shift_in, {NAW{1'b0}}};
    assign stack_raddr = SAW'(level_reg - 1'b1);
    assign stack_waddr = SAW'(level_base);
    assign node_raddr  = child_addr;

    // tree build and decode sequencing
    always_comb
    begin
        phase_next     = phase_eff;
        nfn_next       = nfn_reg;
        level_next     = level_reg;
        sym_cnt_next   = sym_cnt_reg;
        shift_next     = shift_reg;
        bytes_next     = bytes_eff;
        cur_idx_next   = cur_idx_eff;
        cur_entry_next = cur_entry_eff;
        s1_valid_next  = 1'b0;
        s1_err_next    = 1'b0;
        s1_addr_next   = child_addr;
        link_pend_next = 1'b0;
        link_addr_next = stack_rd_reg;
        link_data_next = '0;
        leaf_we        = 1'b0;
        stack_we       = 1'b0;

        if (accept)
        begin
            // a new stream restarts tree loading
            if (code_ch.start_req)
            begin
                phase_next   = htbd_pkg::PH_FLAG;
                nfn_next     = '0;
                level_next   = '0;
                sym_cnt_next = '0;
                shift_next   = '0;
                bytes_next   = '0;
            end

            case (phase_next)
                htbd_pkg::PH_FLAG:
                begin
                    if (nfn_next >= NODE_FULL)
                    begin
                        phase_next    = htbd_pkg::PH_ERROR;
                        s1_valid_next = 1'b1;
                        s1_err_next   = 1'b1;
                    end
                    else if (!code_ch.in_bit)
                    begin
                        if (level_next >= STACK_FULL)
                        begin
                            phase_next    = htbd_pkg::PH_ERROR;
                            s1_valid_next = 1'b1;
                            s1_err_next   = 1'b1;
                        end
                        else
                        begin
                            // internal node waits on the stack for its right link
                            stack_we   = 1'b1;
                            level_next = level_next + 1'b1;
                            nfn_next   = nfn_inc;
                        end
                    end
                    else
                    begin
                        sym_cnt_next = '0;
                        shift_next   = '0;
                        phase_next   = htbd_pkg::PH_SYMBOL;
                    end
                end

                htbd_pkg::PH_SYMBOL:
                begin
                    shift_next = shift_in;
                    if (sym_cnt_reg == SYM_LAST)
                    begin
                        sym_cnt_next = '0;
                        leaf_we      = 1'b1;
                        nfn_next     = nfn_inc;
                        if (level_reg == '0)
                        begin
                            // tree complete, decode starts at the root
                            cur_idx_next   = '0;
                            cur_entry_next = (nfn_reg == '0) ? leaf_entry : root_reg;
                            phase_next     = len_reached ? htbd_pkg::PH_DONE
                                                         : htbd_pkg::PH_DECODE;
                        end
                        else
                        begin
                            // pop: link the waiting node to the next free index
                            level_next     = level_reg - 1'b1;
                            link_pend_next = 1'b1;
                            link_data_next = nfn_inc[NAW-1:0];
                            phase_next     = htbd_pkg::PH_FLAG;
                        end
                    end
                    else
                    begin
                        sym_cnt_next = sym_cnt_reg + 1'b1;
                    end
                end

                htbd_pkg::PH_DECODE:
                begin
                    if (len_reached)
                    begin
                        phase_next = htbd_pkg::PH_DONE;
                    end
                    else
                    begin
                        s1_valid_next = 1'b1;
                    end
                end

                default:
                begin
                    phase_next = phase_next;
                end
            endcase
        end
    end

    // node memory write port: leaf entries, then deferred link writes
    always_comb
    begin
        if (leaf_we)
        begin
            node_we    = 1'b1;
            node_waddr = nfn_reg[NAW-1:0];
            node_wdata = leaf_entry;
        end
        else
        begin
            node_we    = link_pend_reg;
            node_waddr = link_addr_reg;
            node_wdata = {1'b0, {htbd_pkg::SYM_BITS{1'b0}}, link_data_reg};
        end
        root_next = (node_we && node_waddr == '0) ? node_wdata : root_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= htbd_pkg::PH_FLAG;
            nfn_reg       <= '0;
            level_reg     <= '0;
            sym_cnt_reg   <= '0;
            bytes_reg     <= '0;
            total_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            link_pend_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            nfn_reg       <= nfn_next;
            level_reg     <= level_next;
            sym_cnt_reg   <= sym_cnt_next;
            bytes_reg     <= bytes_next;
            s1_valid_reg  <= s1_valid_next;
            link_pend_reg <= link_pend_next;
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        cur_idx_reg   <= cur_idx_next;
        cur_entry_reg <= cur_entry_next;
        root_reg      <= root_next;
        s1_err_reg    <= s1_err_next;
        s1_addr_reg   <= s1_addr_next;
        link_addr_reg <= link_addr_next;
        link_data_reg <= link_data_next;
    end

    // node memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rd_reg <= node_mem[node_raddr];
    end

    // pending stack, top entry read every cycle
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= nfn_base[NAW-1:0];
        end
        stack_rd_reg <= stack_mem[stack_raddr];
    end

    // result queue toward the receiver
    htbd_out_queue u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .fill   (q_fill),
        .sym_ch (sym_ch)
    );

endmodule

`default_nettype wire

### hw/rtl/htbd_checker.sv
// Port-level checks of the Huffman tree bit decoder and their bind.
// Watches code_ch, sym_ch and reset of huffman_tree_bit_decoder.
// Depends on the top level; compiled after it.
`timescale 1ns / 1ps
`default_nettype none

module htbd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       last_byte,
    input wire logic       tree_error
);

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(last_byte) && $stable(tree_error))
    else $error("result changed while stalled");

    // a new result follows its input transfer through the node read register and the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a prior input transfer");

    // input is throttled only while results are waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

    // the error result carries no byte and no end mark
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tree_error |-> out_byte == 8'd0 && !last_byte)
    else $error("error result with payload");

endmodule

bind huffman_tree_bit_decoder htbd_checker u_htbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (code_ch.valid),
    .in_ready   (code_ch.ready),
    .out_valid  (sym_ch.valid),
    .out_ready  (sym_ch.ready),
    .out_byte   (sym_ch.out_byte),
    .last_byte  (sym_ch.last_byte),
    .tree_error (sym_ch.tree_error)
);

`default_nettype wire

### verif/huffman_tree_bit_decoder_test.sv
// Self-checking test of huffman_tree_bit_decoder: coded bits in, decoded bytes out.
// Depends on htbd_pkg, htbd_channels and the block's RTL; keeps its own tree decoder
// that tracks the block bit by bit and checks every byte transfer against it.
`timescale 1ns / 1ps

module huffman_tree_bit_decoder_test;

    localparam int NODE_DEPTH = 512;
    localparam int STACK_DEPTH = 256;
    localparam logic [htbd_pkg::LEN_W-1:0] LEN_MAX = '1;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;

    // length register value
    typedef logic [htbd_pkg::LEN_W-1:0] len_t;

    // one rebuilt tree node: leaf flag, symbol, right-child link
    typedef struct packed {
        logic        leaf;
        logic [7:0]  sym;
        logic [12:0] link;
    } tree_node_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    len_t cfg_wdata;

    htbd_code_if code_ch ();
    htbd_sym_if sym_ch ();

    huffman_tree_bit_decoder #(
        .NODE_DEPTH(NODE_DEPTH),
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .code_ch(code_ch),
        .sym_ch(sym_ch),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // clock, 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow decoder state
    tree_node_t        node_mem[NODE_DEPTH];
    int unsigned       open_nodes[STACK_DEPTH];
    int unsigned       open_cnt;
    int unsigned       free_idx;
    int unsigned       cur_idx;
    int unsigned       sym_cnt;
    logic [7:0]        sym_acc;
    len_t              emitted;
    len_t              total_len;
    htbd_pkg::phase_t  tree_phase;

    // bytes still owed by the block, oldest first
    htbd_pkg::result_t bytes_due[$];
    // coded bits waiting to be sent
    logic              bit_q[$];

    int  bits_sent = 0;
    int  bytes_checked = 0;
    int  streams_opened = 0;
    int  tree_errors = 0;
    int  fail_count = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;
    int  rx_hold = 0;

    function automatic void restart_tree();
        open_cnt = 0;
        free_idx = 0;
        cur_idx = 0;
        sym_cnt = 0;
        sym_acc = '0;
        emitted = '0;
        tree_phase = htbd_pkg::PH_FLAG;
    endfunction

    // advance the shadow decoder by one coded bit; returns 1 when a byte is due
    function automatic bit tree_decode_step(input logic b, input logic s,
                                            output htbd_pkg::result_t r);
        tree_node_t  ent;
        int unsigned child;
        r = '0;
        if (s)
            restart_tree();
        case (tree_phase)
            htbd_pkg::PH_FLAG:
            begin
                if (free_idx >= NODE_DEPTH)
                begin
                    tree_phase = htbd_pkg::PH_ERROR;
                    r.tree_error = 1'b1;
                    return 1'b1;
                end
                if (!b)
                begin
                    if (open_cnt >= STACK_DEPTH)
                    begin
                        tree_phase = htbd_pkg::PH_ERROR;
                        r.tree_error = 1'b1;
                        return 1'b1;
                    end
                    node_mem[free_idx] = '0;
                    open_nodes[open_cnt] = free_idx;
                    open_cnt++;
                    free_idx++;
                end
                else
                begin
                    sym_cnt = 0;
                    sym_acc = '0;
                    tree_phase = htbd_pkg::PH_SYMBOL;
                end
                return 1'b0;
            end
            htbd_pkg::PH_SYMBOL:
            begin
                sym_acc = {sym_acc[6:0], b};
                sym_cnt++;
                if (sym_cnt < 8)
                    return 1'b0;
                sym_cnt = 0;
                if (free_idx < NODE_DEPTH)
                    node_mem[free_idx] = {1'b1, sym_acc, 13'd0};
                free_idx++;
                if (open_cnt == 0)
                begin
                    cur_idx = 0;
                    tree_phase = (emitted >= total_len) ? htbd_pkg::PH_DONE
                                                        : htbd_pkg::PH_DECODE;
                end
                else
                begin
                    // left subtree closed, link the right child of the parent
                    open_cnt--;
                    if (open_nodes[open_cnt] < NODE_DEPTH)
                        node_mem[open_nodes[open_cnt]] = {1'b0, 8'd0, 13'(free_idx)};
                    tree_phase = htbd_pkg::PH_FLAG;
                end
                return 1'b0;
            end
            htbd_pkg::PH_DECODE:
            begin
                if (emitted >= total_len)
                begin
                    tree_phase = htbd_pkg::PH_DONE;
                    return 1'b0;
                end
                ent = (cur_idx < NODE_DEPTH) ? node_mem[cur_idx] : '0;
                if (ent.leaf)
                    child = cur_idx;
                else
                begin
                    child = b ? int'(ent.link) : cur_idx + 1;
                    ent = (child < NODE_DEPTH) ? node_mem[child] : '0;
                end
                if (!ent.leaf)
                begin
                    cur_idx = (child < NODE_DEPTH) ? child : 0;
                    return 1'b0;
                end
                cur_idx = 0;
                emitted = emitted + 1'b1;
                r.out_byte = ent.sym;
                r.last_byte = (emitted >= total_len);
                if (r.last_byte)
                    tree_phase = htbd_pkg::PH_DONE;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // send one coded bit and record what the block owes for it
    task automatic send_bit(input logic b, input logic s);
        int                gap;
        bit                ok;
        htbd_pkg::result_t res;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            code_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        code_ch.valid <= 1'b1;
        code_ch.in_bit <= b;
        code_ch.start_req <= s;
        do
        begin
            @(negedge clk);
            ok = (code_ch.ready === 1'b1);
            @(posedge clk);
        end while (!ok);
        bits_sent++;
        if (s)
            streams_opened++;
        if (tree_decode_step(b, s, res))
        begin
            bytes_due.insert(bytes_due.size(), res);
            if (res.tree_error)
                tree_errors++;
        end
    endtask

    task automatic send_queue(input bit open_stream);
        int i;
        for (i = 0; i < bit_q.size(); i++)
            send_bit(bit_q[i], open_stream && i == 0);
        bit_q.delete();
    endtask

    // append one coded bit to the send list
    function automatic void add_bit(input logic b);
        bit_q.insert(bit_q.size(), b);
    endfunction

    // leaf flag then symbol, msb first
    function automatic void push_leaf(input logic [7:0] sym);
        int i;
        add_bit(1'b1);
        for (i = 7; i >= 0; i--)
            add_bit(sym[i]);
    endfunction

    // random preorder tree with at most the given number of internal nodes
    function automatic void push_tree(input int internals);
        int slots;
        int made;
        slots = 1;
        made = 0;
        while (slots > 0)
        begin
            if (made < internals && $urandom_range(0, 2) != 0)
            begin
                add_bit(1'b0);
                made++;
                slots++;
            end
            else
            begin
                push_leaf(8'($urandom_range(0, 255)));
                slots--;
            end
        end
    endfunction

    function automatic void push_random(input int n);
        int i;
        for (i = 0; i < n; i++)
            add_bit(1'($urandom_range(0, 1)));
    endfunction

    // stop offering and wait until every owed byte has arrived
    task automatic drain_results();
        code_ch.valid <= 1'b0;
        while (bytes_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input len_t v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        total_len = v;
    endtask

    // tree bits arriving before any start_req load a stream
    task automatic test_load_before_start();
        write_length(len_t'(3));
        add_bit(1'b0);
        push_leaf(8'h00);
        push_leaf(8'hFF);
        add_bit(1'b0);
        add_bit(1'b1);
        add_bit(1'b1);
        add_bit(1'b0);
        send_queue(1'b0);
        drain_results();
    endtask

    // single leaf: every data bit emits the leaf byte until the length is reached
    task automatic test_single_leaf();
        write_length(len_t'(4));
        push_leaf(8'hA5);
        add_bit(1'b0);
        add_bit(1'b1);
        add_bit(1'b1);
        add_bit(1'b0);
        add_bit(1'b1);
        send_queue(1'b1);
        drain_results();
    endtask

    // zero length: complete tree, no byte
    task automatic test_zero_length();
        write_length('0);
        add_bit(1'b0);
        push_leaf(8'h5A);
        push_leaf(8'h81);
        push_random(3);
        send_queue(1'b1);
        drain_results();
    endtask

    // length lowered under the bytes already emitted ends the stream
    task automatic test_length_lowered();
        write_length(LEN_MAX);
        add_bit(1'b0);
        push_leaf(8'h3C);
        push_leaf(8'hC3);
        push_random(6);
        send_queue(1'b1);
        drain_results();
        write_length(len_t'(2));
        push_random(3);
        send_queue(1'b0);
        drain_results();
        push_leaf(8'h00);
        push_random(3);
        send_queue(1'b1);
        drain_results();
    endtask

    // start_req in the middle of a leaf symbol restarts tree loading
    task automatic test_restart_in_tree();
        write_length(len_t'(2));
        add_bit(1'b0);
        add_bit(1'b1);
        push_random(4);
        send_queue(1'b1);
        add_bit(1'b0);
        add_bit(1'b0);
        push_leaf(8'h11);
        push_leaf(8'h22);
        push_leaf(8'h33);
        add_bit(1'b0);
        add_bit(1'b0);
        add_bit(1'b1);
        send_queue(1'b1);
        drain_results();
    endtask

    // too many open internal nodes overflow the stack
    task automatic test_stack_overflow();
        int i;
        write_length(len_t'(5));
        for (i = 0; i <= STACK_DEPTH; i++)
            add_bit(1'b0);
        push_random(6);
        send_queue(1'b1);
        push_leaf(8'h7E);
        push_random(2);
        send_queue(1'b1);
        drain_results();
    endtask

    // full stack, then leaf and internal pairs fill the node store; next flag overflows
    task automatic test_node_overflow();
        int i;
        for (i = 0; i < STACK_DEPTH; i++)
            add_bit(1'b0);
        for (i = 0; i < (NODE_DEPTH - STACK_DEPTH) / 2; i++)
        begin
            push_leaf(8'($urandom_range(0, 255)));
            add_bit(1'b0);
        end
        push_random(4);
        send_queue(1'b1);
        add_bit(1'b0);
        push_leaf(8'hE7);
        push_leaf(8'h18);
        push_random(6);
        send_queue(1'b1);
        drain_results();
    endtask

    // long receiver hold-off fills the result queue and stalls the input
    task automatic test_output_stall();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        write_length(len_t'(60));
        add_bit(1'b0);
        push_leaf(8'($urandom_range(0, 255)));
        push_leaf(8'($urandom_range(0, 255)));
        send_queue(1'b1);
        rx_hold = 200;
        push_random(64);
        send_queue(1'b0);
        drain_results();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // random streams: mostly well-formed trees with random data, some cut short, some noise
    task automatic test_random_streams();
        int          phase_n;
        int          first_bit;
        int          pick;
        int          n;
        int          k;
        logic [63:0] wide;
        for (phase_n = 0; phase_n < 8; phase_n++)
        begin
            drain_results();
            case (phase_n)
                0: write_length('0);
                1: write_length(LEN_MAX);
                2:
                begin
                    wide = {$urandom, $urandom};
                    write_length(wide[htbd_pkg::LEN_W-1:0]);
                end
                default: write_length(len_t'($urandom_range(1, 16)));
            endcase
            tx_idle = (phase_n % 3) != 1;
            rx_idle = (phase_n % 4) != 2;
            first_bit = bits_sent;
            while (bits_sent - first_bit < 40)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    push_tree(($urandom_range(0, 9) == 0) ? $urandom_range(6, 20)
                                                          : $urandom_range(0, 5));
                    push_random($urandom_range(1, 40));
                    send_queue(1'b1);
                end
                else if (pick < 90)
                begin
                    push_tree($urandom_range(0, 4));
                    n = $urandom_range(1, bit_q.size() - 1);
                    while (bit_q.size() > n)
                        void'(bit_q.pop_back());
                    send_queue(1'b1);
                end
                else
                begin
                    n = $urandom_range(1, 10);
                    for (k = 0; k < n; k++)
                        send_bit(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
                end
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // receiver: random ready, checks every byte transfer against the oldest owed byte
    initial
    begin
        int                gap;
        bit                took;
        htbd_pkg::result_t got;
        htbd_pkg::result_t want;
        sym_ch.ready = 1'b0;
        forever
        begin
            gap = (rx_hold > 0) ? rx_hold : (rx_idle ? $urandom_range(0, 9) : 0);
            rx_hold = 0;
            if (gap > 0)
            begin
                sym_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            sym_ch.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = (sym_ch.valid === 1'b1);
                if (took)
                begin
                    got.out_byte = sym_ch.out_byte;
                    got.last_byte = sym_ch.last_byte;
                    got.tree_error = sym_ch.tree_error;
                    bytes_checked++;
                    if (bytes_due.size() == 0)
                    begin
                        $error("unexpected transfer: out_byte %0h last_byte %0b tree_error %0b",
                               got.out_byte, got.last_byte, got.tree_error);
                        fail_count++;
                    end
                    else
                    begin
                        want = bytes_due.pop_front();
                        if (got.out_byte !== want.out_byte)
                        begin
                            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                            fail_count++;
                        end
                        if (got.last_byte !== want.last_byte)
                        begin
                            $error("last_byte: expected %0b, got %0b",
                                   want.last_byte, got.last_byte);
                            fail_count++;
                        end
                        if (got.tree_error !== want.tree_error)
                        begin
                            $error("tree_error: expected %0b, got %0b",
                                   want.tree_error, got.tree_error);
                            fail_count++;
                        end
                    end
                end
                @(posedge clk);
            end while (!took);
        end
    end

    // watchdog: too long without any transfer on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((code_ch.valid === 1'b1 && code_ch.ready === 1'b1) ||
                (sym_ch.valid === 1'b1 && sym_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // reset, then the tests in turn
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        code_ch.valid = 1'b0;
        code_ch.in_bit = 1'b0;
        code_ch.start_req = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        restart_tree();
        total_len = '0;

        test_load_before_start();
        test_single_leaf();
        test_zero_length();
        test_length_lowered();
        test_restart_in_tree();
        test_stack_overflow();
        test_node_overflow();
        test_output_stall();
        test_random_streams();
        drain_results();

        $display("tb: %0d coded bits over %0d streams, %0d byte transfers checked",
                 bits_sent, streams_opened, bytes_checked);
        $display("tb: %0d tree overflows seen, %0d mismatches", tree_errors, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
hw/rtl/htbd_pkg.sv
hw/rtl/htbd_channels.sv
hw/rtl/htbd_out_queue.sv
hw/rtl/huffman_tree_bit_decoder.sv
hw/rtl/htbd_checker.sv
verif/huffman_tree_bit_decoder_test.sv
